/* hdl/wde_pkg.sv */
// ----------------------------------------------------------------------------
// wde_pkg: shared types and constants for the WS2812 dimmed bit encoder
// Register codes, configuration bundle, job format and the dimming gain table.
// ----------------------------------------------------------------------------
package wde_pkg;

  localparam int RESET_SLOTS    = 50;
  localparam int BITS_PER_PIXEL = 24;
  localparam int MAX_BRIGHTNESS = 45;

  localparam int SLOT_MAX = (RESET_SLOTS > BITS_PER_PIXEL) ? RESET_SLOTS : BITS_PER_PIXEL;
  localparam int CNT_W    = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
  localparam int GAIN_W   = 17;
  localparam int BRT_W    = 6;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_DIM_EN     = 2'd1,
    REG_DUTY_ONE   = 2'd2,
    REG_DUTY_ZERO  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BRT_W-1:0] brightness;
    logic             dim_en;
    logic [7:0]       duty_one;
    logic [7:0]       duty_zero;
  } cfg_t;

  typedef struct packed {
    logic                      latch;
    logic [BITS_PER_PIXEL-1:0] word;
  } slot_job_t;

  localparam logic [GAIN_W-1:0] GAIN_TABLE [0:45] = '{
    17'd52,    17'd1196,  17'd2340,  17'd3485,  17'd4633,  17'd5783,  17'd6937,  17'd8096,
    17'd9259,  17'd10428, 17'd11604, 17'd12786, 17'd13977, 17'd15177, 17'd16387, 17'd17607,
    17'd18839, 17'd20083, 17'd21340, 17'd22612, 17'd23899, 17'd25203, 17'd26524, 17'd27864,
    17'd29224, 17'd30606, 17'd32010, 17'd33438, 17'd34892, 17'd36373, 17'd37884, 17'd39425,
    17'd40998, 17'd42607, 17'd44252, 17'd45936, 17'd47663, 17'd49433, 17'd51251, 17'd53119,
    17'd55041, 17'd57019, 17'd59059, 17'd61164, 17'd63339, 17'd65588
  };

  function automatic logic [GAIN_W-1:0] gain_lookup(input logic [BRT_W-1:0] b);
    logic [BRT_W-1:0] c;
    c = (b > BRT_W'(MAX_BRIGHTNESS)) ? BRT_W'(MAX_BRIGHTNESS) : b;
    return GAIN_TABLE[c];
  endfunction

endpackage

/* hdl/ws2812_dimmed_bit_encoder.sv */
// ----------------------------------------------------------------------------
// ws2812_dimmed_bit_encoder: WS2812 pixel to PWM duty slot encoder
// Scales G,R,B bytes by a brightness gain when dimming is on and emits one duty per bit slot.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer; in_mode 0 is a pixel (red, green, blue),
//           in_mode 1 is a latch that emits RESET_SLOTS zero duties.
//   out_* : one duty slot per transfer, MSB of the G,R,B word first;
//           out_last marks the final slot of each item's run.
//   cfg_* : register writes (brightness, dimming enable, one and zero duties),
//           always ready; write only while the encoder is idle.
// Path: front stage register, job queue, serializer shift register, output register.
// Throughput: one slot per cycle while out_ready is high, set by the serializer
//   in the back end; a pixel is BITS_PER_PIXEL slots and a latch RESET_SLOTS; a two-entry
//   job queue lets the front scale the next pixels while the current one is shifted out.
// Reset: synchronous, clears the pipeline and queue and restores the register
//   defaults (brightness 45, dimming on, duties 60 and 30).
// Stall: when out_ready is low the slot holds in the output register; the
//   serializer, then the queue, then in_ready back up in turn.
// ----------------------------------------------------------------------------
module ws2812_dimmed_bit_encoder import wde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_duty,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t      cfg_r;
  logic      fq_valid;
  logic      fq_ready;
  slot_job_t fq_data;
  logic      qb_valid;
  logic      qb_ready;
  slot_job_t qb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness <= BRT_W'(45);
      cfg_r.dim_en     <= 1'b1;
      cfg_r.duty_one   <= 8'd60;
      cfg_r.duty_zero  <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BRIGHTNESS: cfg_r.brightness <= cfg_data[BRT_W-1:0];
        REG_DIM_EN:     cfg_r.dim_en     <= cfg_data[0];
        REG_DUTY_ONE:   cfg_r.duty_one   <= cfg_data;
        REG_DUTY_ZERO:  cfg_r.duty_zero  <= cfg_data;
        default: ;
      endcase
    end
  end

  wde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg       (cfg_r),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job_data  (fq_data)
  );

  wde_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  wde_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_duty  (out_duty),
    .out_last  (out_last)
  );

endmodule

/* hdl/wde_front.sv */
// ----------------------------------------------------------------------------
// wde_front: input stage of the encoder
// Accepts pixel and latch items, scales the colour bytes when dimming is on and packs G,R,B.
// ----------------------------------------------------------------------------
module wde_front import wde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_mode,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  cfg_t       cfg,
  output logic       job_valid,
  input  logic       job_ready,
  output slot_job_t  job_data
);

  logic              s1_valid_r;
  logic              s1_latch_r;
  logic              s1_dim_r;
  logic [7:0]        s1_red_r;
  logic [7:0]        s1_green_r;
  logic [7:0]        s1_blue_r;
  logic [GAIN_W-1:0] s1_gain_r;

  logic [7:0]        red_dim;
  logic [7:0]        green_dim;
  logic [7:0]        blue_dim;

  function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [GAIN_W-1:0] g);
    logic [GAIN_W+7:0] p;
    logic [8:0]        s;
    p = (GAIN_W+8)'(v) * (GAIN_W+8)'(g);
    s = p[GAIN_W+7:16];
    return (s > 9'd255) ? 8'hFF : s[7:0];
  endfunction

  assign in_ready = !s1_valid_r || job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_latch_r <= in_mode;
      s1_dim_r   <= cfg.dim_en;
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_gain_r  <= gain_lookup(cfg.brightness);
    end
  end

  always_comb begin
    if (s1_dim_r) begin
      red_dim   = scale_byte(s1_red_r, s1_gain_r);
      green_dim = scale_byte(s1_green_r, s1_gain_r);
      blue_dim  = scale_byte(s1_blue_r, s1_gain_r);
    end else begin
      red_dim   = s1_red_r;
      green_dim = s1_green_r;
      blue_dim  = s1_blue_r;
    end
  end

  assign job_valid      = s1_valid_r;
  assign job_data.latch = s1_latch_r;
  assign job_data.word  = {green_dim, red_dim, blue_dim};

endmodule

/* hdl/wde_queue.sv */
// ----------------------------------------------------------------------------
// wde_queue: short job queue between front and back
// Decouples pixel scaling from slot serialization.
// ----------------------------------------------------------------------------
module wde_queue import wde_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  slot_job_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output slot_job_t pop_data
);

  slot_job_t            entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic                 push;
  logic                 pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entries_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

endmodule

/* hdl/wde_back.sv */
// ----------------------------------------------------------------------------
// wde_back: slot serializer
// Shifts a job out MSB first as one duty value per cycle into the output register while out_ready does not stall it.
// ----------------------------------------------------------------------------
module wde_back import wde_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  output logic       job_ready,
  input  slot_job_t  job_data,
  input  cfg_t       cfg,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_duty,
  output logic       out_last
);

  logic                      busy_r;
  logic                      latch_r;
  logic [BITS_PER_PIXEL-1:0] word_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      out_valid_r;
  logic [7:0]                out_duty_r;
  logic                      out_last_r;

  logic                      out_load;
  logic                      last_slot;
  logic [CNT_W-1:0]          end_cnt;
  logic [7:0]                duty_nxt;

  assign out_load  = !out_valid_r || out_ready;
  assign end_cnt   = latch_r ? CNT_W'(RESET_SLOTS - 1) : CNT_W'(BITS_PER_PIXEL - 1);
  assign last_slot = busy_r && (cnt_r == end_cnt);
  assign job_ready = !busy_r || (out_load && last_slot);

  always_comb begin
    if (latch_r) begin
      duty_nxt = 8'd0;
    end else if (word_r[BITS_PER_PIXEL-1]) begin
      duty_nxt = cfg.duty_one;
    end else begin
      duty_nxt = cfg.duty_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= busy_r;
      if (job_ready) begin
        busy_r <= job_valid;
        cnt_r  <= '0;
      end else if (busy_r && out_load) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      latch_r <= job_data.latch;
      word_r  <= job_data.word;
    end else if (busy_r && out_load) begin
      word_r  <= {word_r[BITS_PER_PIXEL-2:0], 1'b0};
    end
    if (busy_r && out_load) begin
      out_duty_r <= duty_nxt;
      out_last_r <= last_slot;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty  = out_duty_r;
  assign out_last  = out_last_r;

endmodule

/* hdl/wde_checker.sv */
// ----------------------------------------------------------------------------
// wde_checker: port-level checks for the encoder
// Watches reset behavior, slot stalls, back-to-back slot delivery and register write acceptance.
// ----------------------------------------------------------------------------
module wde_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_duty,
  input logic       out_last,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("outputs not cleared after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_last))
    else $error("stalled slot changed");

  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a slot run");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write not taken");

endmodule

bind ws2812_dimmed_bit_encoder wde_checker u_wde_checker (.*);
